### hw/rtl/chm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Convex hull package
// Shared sizes, the point type, the point order and the structs that travel
// between the loader, the job queue and the hull engine.
// ----------------------------------------------------------------------------
package chm_pkg;

  localparam int MAX_POINTS = 64;
  localparam int COORD_BITS = 32;
  localparam int IO_W       = 32;
  localparam int PT_AW      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int HULL_DEPTH = 2 * MAX_POINTS;
  localparam int HULL_AW    = $clog2(HULL_DEPTH);
  localparam int K_W        = HULL_AW + 1;
  localparam int PT_W       = 2 * COORD_BITS;
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int CROSS_W    = PROD_W + 1;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  // One finished point set waiting for the hull engine.
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             trunc;
  } job_t;

  // Point store access from the loader.
  typedef struct packed {
    logic             we;
    logic [PT_AW-1:0] waddr;
    point_t           wdata;
    logic [PT_AW-1:0] raddr;
  } pt_port_t;

  // Order by x, then by y.
  function automatic logic pt_less(point_t a, point_t b);
    return (a.x < b.x) || ((a.x == b.x) && (a.y < b.y));
  endfunction

endpackage

### hw/rtl/chm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module chm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read data registered; a read of the word being written returns its old value.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/chm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point loader
// Takes one point per word and inserts it into the point store in sorted
// order, so the store is already sorted when the last point arrives. On the
// last point it hands the set size and the overflow flag to the job queue.
// ----------------------------------------------------------------------------
module chm_front import chm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  take,
  input  logic signed [IO_W-1:0] px,
  input  logic signed [IO_W-1:0] py,
  input  logic                  final_point,
  input  point_t                rdata,
  output pt_port_t              port,
  output logic                  active,
  output logic                  job_push,
  output job_t                  job
);

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_RD   = 4'b0010,
    F_CMP  = 4'b0100,
    F_FIN  = 4'b1000
  } fstate_t;

  fstate_t          state, state_next;
  logic [CNT_W-1:0] count;
  logic             overflow;
  logic [PT_AW-1:0] j;
  point_t           vin;
  logic             fin;
  logic             stored;

  assign active = (state != F_IDLE);

  // Insertion walk: read the entry below, shift it up or write the new point.
  always_comb begin
    state_next    = state;
    port.we       = 1'b0;
    port.waddr    = j;
    port.wdata    = vin;
    port.raddr    = j - 1'b1;
    job_push      = 1'b0;
    job.count     = count + CNT_W'(stored);
    job.trunc     = overflow;
    unique case (state)
      F_IDLE: begin
        if (take) begin
          state_next = (count == CNT_W'(MAX_POINTS)) ? F_FIN : F_RD;
        end
      end
      F_RD: begin
        if (j == '0) begin
          port.we    = 1'b1;
          state_next = F_FIN;
        end else begin
          state_next = F_CMP;
        end
      end
      F_CMP: begin
        port.we = 1'b1;
        if (pt_less(vin, rdata)) begin
          port.wdata = rdata;
          state_next = F_RD;
        end else begin
          state_next = F_FIN;
        end
      end
      F_FIN: begin
        job_push   = fin;
        state_next = F_IDLE;
      end
      default: state_next = F_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= F_IDLE;
      count    <= '0;
      overflow <= 1'b0;
    end else begin
      state <= state_next;
      if (state == F_IDLE && take && count == CNT_W'(MAX_POINTS)) begin
        overflow <= 1'b1;
      end
      if (state == F_FIN) begin
        if (fin) begin
          count    <= '0;
          overflow <= 1'b0;
        end else begin
          count <= count + CNT_W'(stored);
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (state == F_IDLE && take) begin
      vin    <= '{x: px[COORD_BITS-1:0], y: py[COORD_BITS-1:0]};
      fin    <= final_point;
      stored <= (count != CNT_W'(MAX_POINTS));
      j      <= count[PT_AW-1:0];
    end else if (state == F_CMP && pt_less(vin, rdata)) begin
      j <= j - 1'b1;
    end
  end

endmodule

### hw/rtl/chm_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Job queue
// Two-entry queue of finished point sets between the loader and the engine.
// ----------------------------------------------------------------------------
module chm_queue import chm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t din,
  input  logic pop,
  output logic valid,
  output logic full,
  output job_t dout
);

  job_t       slots [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] fill;

  assign valid = (fill != 2'd0);
  assign full  = (fill == 2'd2);
  assign dout  = slots[rptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= din;
    end
  end

endmodule

### hw/rtl/chm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hull engine
// Walks the sorted point store for the lower and then the upper chain, keeps
// the chain in a stack memory with its top two entries in registers, tests
// each turn with an exact cross product, and streams the hull.
// ----------------------------------------------------------------------------
module chm_back import chm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   job_valid,
  input  job_t                   job,
  output logic                   job_pop,
  output logic [PT_AW-1:0]       pt_raddr,
  input  point_t                 pt_rdata,
  output logic                   active,
  output logic                   strobe,
  output logic signed [IO_W-1:0] hx,
  output logic signed [IO_W-1:0] hy,
  output logic                   last_vertex,
  output logic                   too_few,
  output logic                   truncated
);

  typedef enum logic [9:0] {
    B_IDLE = 10'b0000000001,
    B_FEW  = 10'b0000000010,
    B_RD   = 10'b0000000100,
    B_CHK  = 10'b0000001000,
    B_T1   = 10'b0000010000,
    B_T2   = 10'b0000100000,
    B_T3   = 10'b0001000000,
    B_POPW = 10'b0010000000,
    B_PUSH = 10'b0100000000,
    B_EMIT = 10'b1000000000
  } bstate_t;

  bstate_t                    state, state_next;
  logic [CNT_W-1:0]           n;
  logic                       trunc;
  logic [PT_AW-1:0]           i;
  logic [K_W-1:0]             k;
  logic [K_W-1:0]             t;
  logic [K_W-1:0]             kfin;
  logic [K_W-1:0]             v;
  logic                       lower;
  point_t                     top_a;
  point_t                     top_b;
  point_t                     cur;
  logic signed [DIFF_W-1:0]   dax, dby, day, dbx;
  logic signed [PROD_W-1:0]   p1, p2;
  logic signed [CROSS_W-1:0]  cross_val;
  logic                       left_turn;
  logic [CNT_W-1:0]           n_m1;
  logic [CNT_W-1:0]           n_m2;
  logic                       em_vld;
  logic                       em_last;
  logic                       hull_we;
  logic [HULL_AW-1:0]         hull_raddr;
  logic [K_W-1:0]             k_m3;
  point_t                     hull_rdata;
  logic                       at_limit;
  logic                       emit_end;

  assign active    = (state != B_IDLE);
  assign pt_raddr  = i;
  assign n_m1      = n - CNT_W'(1);
  assign n_m2      = n - CNT_W'(2);
  assign k_m3      = k - K_W'(3);
  assign cross_val = CROSS_W'(p1) - CROSS_W'(p2);
  assign left_turn = !cross_val[CROSS_W-1] && (cross_val != '0);
  assign at_limit  = lower ? (k >= K_W'(2)) : (k >= t);
  assign emit_end  = (v == kfin - K_W'(1));
  assign hull_we   = (state == B_PUSH);
  assign hull_raddr = (state == B_EMIT) ? v[HULL_AW-1:0] : k_m3[HULL_AW-1:0];

  // Chain stack memory.
  chm_ram #(
    .WIDTH(PT_W),
    .DEPTH(HULL_DEPTH)
  ) u_hull_ram (
    .clk  (clk),
    .we   (hull_we),
    .waddr(k[HULL_AW-1:0]),
    .wdata(cur),
    .raddr(hull_raddr),
    .rdata(hull_rdata)
  );

  // Sequencer.
  always_comb begin
    state_next = state;
    job_pop    = 1'b0;
    unique case (state)
      B_IDLE: begin
        if (job_valid) begin
          job_pop    = 1'b1;
          state_next = (job.count < CNT_W'(3)) ? B_FEW : B_RD;
        end
      end
      B_FEW:  state_next = B_IDLE;
      B_RD:   state_next = B_CHK;
      B_CHK:  state_next = at_limit ? B_T1 : B_PUSH;
      B_T1:   state_next = B_T2;
      B_T2:   state_next = B_T3;
      B_T3: begin
        if (left_turn) begin
          state_next = B_PUSH;
        end else if (k >= K_W'(3)) begin
          state_next = B_POPW;
        end else begin
          state_next = B_CHK;
        end
      end
      B_POPW: state_next = B_CHK;
      B_PUSH: begin
        state_next = (!lower && i == '0) ? B_EMIT : B_RD;
      end
      B_EMIT: state_next = emit_end ? B_IDLE : B_EMIT;
      default: state_next = B_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= B_IDLE;
      em_vld <= 1'b0;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      em_vld <= (state == B_EMIT);
      strobe <= em_vld || (state == B_FEW);
    end
  end

  // Walk and stack registers.
  always_ff @(posedge clk) begin
    em_last <= emit_end;
    unique case (state)
      B_IDLE: begin
        n     <= job.count;
        trunc <= job.trunc;
        i     <= '0;
        k     <= '0;
        lower <= 1'b1;
      end
      B_CHK: cur <= pt_rdata;
      B_T1: begin
        dax <= DIFF_W'(top_a.x) - DIFF_W'(top_b.x);
        dby <= DIFF_W'(cur.y) - DIFF_W'(top_b.y);
        day <= DIFF_W'(top_a.y) - DIFF_W'(top_b.y);
        dbx <= DIFF_W'(cur.x) - DIFF_W'(top_b.x);
      end
      B_T2: begin
        p1 <= dax * dby;
        p2 <= day * dbx;
      end
      B_T3: begin
        if (!left_turn) begin
          k     <= k - K_W'(1);
          top_a <= top_b;
        end
      end
      B_POPW: top_b <= hull_rdata;
      B_PUSH: begin
        k     <= k + K_W'(1);
        top_b <= top_a;
        top_a <= cur;
        if (lower) begin
          if ({1'b0, i} == n_m1) begin
            lower <= 1'b0;
            t     <= k + K_W'(2);
            i     <= n_m2[PT_AW-1:0];
          end else begin
            i <= i + 1'b1;
          end
        end else if (i == '0) begin
          kfin <= k;
          v    <= '0;
        end else begin
          i <= i - 1'b1;
        end
      end
      B_EMIT: v <= v + K_W'(1);
      default: begin
      end
    endcase
  end

  // Result word registers.
  always_ff @(posedge clk) begin
    if (state == B_FEW) begin
      hx          <= '0;
      hy          <= '0;
      last_vertex <= 1'b1;
      too_few     <= 1'b1;
      truncated   <= trunc;
    end else if (em_vld) begin
      hx          <= IO_W'(hull_rdata.x);
      hy          <= IO_W'(hull_rdata.y);
      last_vertex <= em_last;
      too_few     <= 1'b0;
      truncated   <= trunc;
    end
  end

endmodule

### hw/rtl/convex_hull_monotone_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Convex hull, monotone chain
// Loads signed points one word at a time and, after the last point, streams
// the convex hull counterclockwise from the least point.
// ----------------------------------------------------------------------------
// A point is taken when start is high and busy is low. Each point is inserted
// into the sorted point store by a walk that holds busy while it shifts up
// each stored point greater than the new one, so presorted input loads
// fastest; a point that arrives when the store is full is dropped. After the
// marked last point the engine runs both chains: it fetches and pushes each
// point, runs each turn test through the pipelined cross product, and on a
// pop refetches the point and the new stack entry through the registered
// reads of the point store and the chain memory. Hull vertices then leave
// at one word per cycle, each on the result ports for exactly one cycle with
// strobe high; they cannot be held off. A set of fewer than three points
// gives one word with too_few set. After the marked last point busy stays
// high until the engine has issued its last read; the final words still
// leave after busy falls.
// ----------------------------------------------------------------------------
module convex_hull_monotone_chain import chm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic signed [IO_W-1:0] px,
  input  logic signed [IO_W-1:0] py,
  input  logic                   final_point,
  output logic                   strobe,
  output logic signed [IO_W-1:0] hx,
  output logic signed [IO_W-1:0] hy,
  output logic                   last_vertex,
  output logic                   too_few,
  output logic                   truncated
);

  pt_port_t         fport;
  point_t           pt_rdata;
  logic [PT_AW-1:0] back_raddr;
  logic [PT_AW-1:0] pt_raddr;
  logic             front_active;
  logic             back_active;
  logic             take;
  logic             job_push;
  job_t             job_in;
  job_t             job_out;
  logic             job_valid;
  logic             job_full;
  logic             job_pop;

  assign take     = start && !busy;
  assign busy     = front_active || back_active || job_valid;
  assign pt_raddr = front_active ? fport.raddr : back_raddr;

  // Sorted point store, shared by loader and engine.
  chm_ram #(
    .WIDTH(PT_W),
    .DEPTH(MAX_POINTS)
  ) u_pt_ram (
    .clk  (clk),
    .we   (fport.we),
    .waddr(fport.waddr),
    .wdata(fport.wdata),
    .raddr(pt_raddr),
    .rdata(pt_rdata)
  );

  chm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .px         (px),
    .py         (py),
    .final_point(final_point),
    .rdata      (pt_rdata),
    .port       (fport),
    .active     (front_active),
    .job_push   (job_push),
    .job        (job_in)
  );

  chm_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (job_push),
    .din  (job_in),
    .pop  (job_pop),
    .valid(job_valid),
    .full (job_full),
    .dout (job_out)
  );

  chm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .job_valid  (job_valid),
    .job        (job_out),
    .job_pop    (job_pop),
    .pt_raddr   (back_raddr),
    .pt_rdata   (pt_rdata),
    .active     (back_active),
    .strobe     (strobe),
    .hx         (hx),
    .hy         (hy),
    .last_vertex(last_vertex),
    .too_few    (too_few),
    .truncated  (truncated)
  );

  // A short set always closes with its single word.
  a_few_is_last: assert property (@(posedge clk) disable iff (rst)
    strobe && too_few |-> last_vertex)
    else $error("too_few word without last_vertex");

  // The loader and the engine never share the point store.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(front_active && back_active))
    else $error("loader and engine active together");

  // A finished set never arrives at a full queue.
  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    job_push |-> !job_full)
    else $error("job pushed into full queue");

  // The engine takes a job only when one waits.
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    job_pop |-> job_valid)
    else $error("job popped from empty queue");

endmodule

### tb/convex_hull_monotone_chain_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Convex hull, monotone chain testbench
// Sends point sets to the hull block and checks every hull word against a
// local monotone-chain hull computed with exact wide cross products. Directed
// sets cover the flagged and degenerate shapes. Random sets follow, some with
// overflow, and the sender pauses in bursts.
// ----------------------------------------------------------------------------
module convex_hull_monotone_chain_tb;
  import chm_pkg::*;

  localparam int WATCHDOG_LIMIT = 40000;
  localparam int DRAIN_CYCLES   = 300;

  typedef struct {
    logic signed [IO_W-1:0] x;
    logic signed [IO_W-1:0] y;
  } vertex_t;

  typedef struct {
    logic signed [IO_W-1:0] x;
    logic signed [IO_W-1:0] y;
    logic                   last;
    logic                   few;
    logic                   trunc;
  } hull_word_t;

  logic                   clk;
  logic                   rst;
  logic                   start;
  logic                   busy;
  logic signed [IO_W-1:0] px;
  logic signed [IO_W-1:0] py;
  logic                   final_point;
  logic                   strobe;
  logic signed [IO_W-1:0] hx;
  logic signed [IO_W-1:0] hy;
  logic                   last_vertex;
  logic                   too_few;
  logic                   truncated;

  // Points of the set being loaded and the hull words still owed.
  vertex_t    loaded_pts[$];
  logic       set_overflow;
  hull_word_t hull_pending[$];
  int         mismatches;
  int         idle_cycles;
  int         burst_left;

  convex_hull_monotone_chain i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .px(px), .py(py), .final_point(final_point),
    .strobe(strobe), .hx(hx), .hy(hy), .last_vertex(last_vertex),
    .too_few(too_few), .truncated(truncated)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Sign of the turn o -> a -> b, exact at 70 bits.
  function automatic int turn_sign(vertex_t o, vertex_t a, vertex_t b);
    logic signed [69:0] ox, oy, ax, ay, bx, by, cross_prod;
    ox = o.x; oy = o.y; ax = a.x; ay = a.y; bx = b.x; by = b.y;
    cross_prod = (ax - ox) * (by - oy) - (ay - oy) * (bx - ox);
    if (cross_prod < 0) return -1;
    return (cross_prod == 0) ? 0 : 1;
  endfunction

  function automatic logic vertex_less(vertex_t a, vertex_t b);
    return (a.x < b.x) || ((a.x == b.x) && (a.y < b.y));
  endfunction

  // Monotone-chain hull of the loaded set, appended to the owed words.
  function automatic void queue_hull(vertex_t pts[$], logic trunc);
    vertex_t    chain[$];
    vertex_t    v;
    hull_word_t w;
    int         n, j, lower;
    n = pts.size();
    if (n < 3) begin
      w = '{x: '0, y: '0, last: 1'b1, few: 1'b1, trunc: trunc};
      hull_pending = {hull_pending, w};
      return;
    end
    for (int i = 1; i < n; i++) begin
      v = pts[i];
      j = i;
      while (j > 0 && vertex_less(v, pts[j-1])) begin
        pts[j] = pts[j-1];
        j--;
      end
      pts[j] = v;
    end
    for (int i = 0; i < n; i++) begin
      while (chain.size() >= 2 &&
             turn_sign(chain[chain.size()-2], chain[chain.size()-1], pts[i]) <= 0)
        chain.delete(chain.size() - 1);
      chain = {chain, pts[i]};
    end
    lower = chain.size() + 1;
    for (int i = n - 2; i >= 0; i--) begin
      while (chain.size() >= lower &&
             turn_sign(chain[chain.size()-2], chain[chain.size()-1], pts[i]) <= 0)
        chain.delete(chain.size() - 1);
      chain = {chain, pts[i]};
    end
    chain.delete(chain.size() - 1);
    foreach (chain[k]) begin
      w = '{x: chain[k].x, y: chain[k].y, last: (k == chain.size() - 1),
            few: 1'b0, trunc: trunc};
      hull_pending = {hull_pending, w};
    end
  endfunction

  // Send one point word; start stays high until the sender decides to pause.
  task automatic send_point(logic signed [IO_W-1:0] x, logic signed [IO_W-1:0] y,
                            logic fin);
    vertex_t v;
    int      gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start       <= 1'b1;
    px          <= x;
    py          <= y;
    final_point <= fin;
    do @(posedge clk); while (busy);
    v = '{x: x, y: y};
    if (loaded_pts.size() < MAX_POINTS) loaded_pts = {loaded_pts, v};
    else set_overflow = 1'b1;
    if (fin) begin
      queue_hull(loaded_pts, set_overflow);
      loaded_pts.delete();
      set_overflow = 1'b0;
    end
  endtask

  function automatic logic signed [IO_W-1:0] rand_coord(int mode);
    case (mode)
      0: return $urandom;
      1: return $signed($urandom_range(0, 16)) - 8;
      default: begin
        case ($urandom_range(0, 2))
          0: return 32'sh8000_0000;
          1: return 32'sh7fff_ffff;
          default: return 0;
        endcase
      end
    endcase
  endfunction

  task automatic send_random_set(int n);
    int mode;
    mode = $urandom_range(0, 2);
    for (int i = 0; i < n; i++)
      send_point(rand_coord(mode), rand_coord(mode), i == n - 1);
  endtask

  // Sets of one and two points give a single flagged word.
  task automatic test_too_few();
    send_point(32'sh7fff_ffff, 32'sh8000_0000, 1'b1);
    send_point(5, -3, 1'b0);
    send_point(-7, 9, 1'b1);
  endtask

  // Triangle at the coordinate extremes.
  task automatic test_extreme_triangle();
    send_point(32'sh8000_0000, 32'sh8000_0000, 1'b0);
    send_point(32'sh7fff_ffff, 32'sh8000_0000, 1'b0);
    send_point(32'sh8000_0000, 32'sh7fff_ffff, 1'b1);
  endtask

  // Collinear points keep only their ends; equal points give two equal vertices.
  task automatic test_degenerate();
    send_point(3, 3, 1'b0);
    send_point(1, 1, 1'b0);
    send_point(2, 2, 1'b0);
    send_point(-4, -4, 1'b1);
    send_point(-1, 6, 1'b0);
    send_point(-1, 6, 1'b0);
    send_point(-1, 6, 1'b1);
  endtask

  // Square with duplicates, an interior point and edge midpoints.
  task automatic test_square();
    send_point(10, 10, 1'b0);
    send_point(0, 0, 1'b0);
    send_point(10, 0, 1'b0);
    send_point(0, 10, 1'b0);
    send_point(5, 5, 1'b0);
    send_point(5, 0, 1'b0);
    send_point(0, 0, 1'b0);
    send_point(0, 5, 1'b1);
  endtask

  // More than a full store: extra points are dropped and flagged.
  task automatic test_overflow();
    send_random_set(MAX_POINTS + 3);
    send_random_set(MAX_POINTS);
  endtask

  task automatic test_random_sets();
    for (int s = 0; s < 40; s++)
      send_random_set(($urandom_range(0, 7) == 0) ? $urandom_range(1, 2)
                                                  : $urandom_range(3, 9));
  endtask

  // Hull word checker; results cannot be held off, so every strobe is taken.
  always @(posedge clk) begin
    hull_word_t want;
    if (!rst && strobe) begin
      if (hull_pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected hull word x=%0d y=%0d last=%0b few=%0b trunc=%0b",
                   hx, hy, last_vertex, too_few, truncated);
      end else begin
        want = hull_pending.pop_front();
        if (hx !== want.x || hy !== want.y || last_vertex !== want.last ||
            too_few !== want.few || truncated !== want.trunc) begin
          mismatches++;
          if (mismatches <= 10)
            $display("hull word mismatch: expected x=%0d y=%0d last=%0b few=%0b trunc=%0b, got x=%0d y=%0d last=%0b few=%0b trunc=%0b",
                     want.x, want.y, want.last, want.few, want.trunc,
                     hx, hy, last_vertex, too_few, truncated);
        end
      end
    end
  end

  // Watchdog on cycles in which no word moves either way.
  always @(posedge clk) begin
    if (rst || strobe || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rst          = 1'b1;
    start        = 1'b0;
    px           = '0;
    py           = '0;
    final_point  = 1'b0;
    set_overflow = 1'b0;
    mismatches   = 0;
    idle_cycles  = 0;
    burst_left   = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_too_few();
    test_extreme_triangle();
    test_degenerate();
    test_square();
    test_overflow();
    test_random_sets();
    start <= 1'b0;
    while (hull_pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && hull_pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/chm_pkg.sv
hw/rtl/chm_ram.sv
hw/rtl/chm_front.sv
hw/rtl/chm_queue.sv
hw/rtl/chm_back.sv
hw/rtl/convex_hull_monotone_chain.sv
tb/convex_hull_monotone_chain_tb.sv
